### src/tfc_pkg.sv
// ----------------------------------------------------------------------------
// tfc_pkg
// Shared types, constants and Q1.15 helpers for the transfer-function
// front-to-back compositor.
// ----------------------------------------------------------------------------
`default_nettype none

package tfc_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam logic [15:0] ONE_Q15      = 16'd32768;
    localparam logic [15:0] CUTOFF_RESET = 16'd32440;

    typedef enum logic {
        REQ_TABLE_WRITE = 1'b0,
        REQ_COMPOSITE   = 1'b1
    } t_req_kind;

    typedef struct packed {
        logic [15:0] alpha;
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
    } t_rgba;

    // one classified beat as it waits in the queue
    typedef struct packed {
        t_req_kind   kind;
        logic [7:0]  index;        // table index (write) or sample value
        logic        out_of_range; // index not inside the table
        logic        last;
        t_rgba       color;        // clamped entry, writes only
    } t_req;

    function automatic logic [15:0] clamp_q15(input logic [15:0] v);
        return (v > ONE_Q15) ? ONE_Q15 : v;
    endfunction

    // (a*b) >> 15, both operands at most 1.0 so the result fits 16 bits
    function automatic logic [15:0] mul_q15(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] p;
        p = {16'd0, a} * {16'd0, b};
        return p[30:15];
    endfunction

    function automatic logic [15:0] add_sat_q15(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, ONE_Q15}) ? ONE_Q15 : s[15:0];
    endfunction

    // (v*255) >> 15, truncated
    function automatic logic [7:0] to_byte(input logic [15:0] v);
        logic [23:0] p;
        p = {v, 8'd0} - {8'd0, v};
        return p[22:15];
    endfunction

endpackage

`default_nettype wire

### src/tfc_front.sv
// ----------------------------------------------------------------------------
// tfc_front
// Accepts input beats, classifies them (table write or sample), clamps
// entry components and range-checks the index, then holds them in a small
// queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tfc_front #(
    parameter int TABLE_ENTRIES = tfc_pkg::TABLE_ENTRIES_DEF,
    parameter int QUEUE_DEPTH   = tfc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic [79:0]   i_s_tdata,
    input  wire logic          i_s_tuser,
    input  wire logic          i_s_tlast,
    output tfc_pkg::t_req      o_head,
    output logic               o_head_valid,
    input  wire logic          i_pop
);

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    tfc_pkg::t_req  r_queue [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_count;

    tfc_pkg::t_req  w_req;
    logic [7:0]     w_index;
    logic           w_push;

    always_comb begin
        w_req.kind = tfc_pkg::t_req_kind'(i_s_tuser);
        w_index    = (w_req.kind == tfc_pkg::REQ_COMPOSITE) ? i_s_tdata[79:72]
                                                            : i_s_tdata[7:0];
        w_req.index        = w_index;
        w_req.out_of_range = ({24'd0, w_index} >= 32'(TABLE_ENTRIES));
        w_req.last         = i_s_tlast;
        w_req.color.red    = tfc_pkg::clamp_q15(i_s_tdata[23:8]);
        w_req.color.green  = tfc_pkg::clamp_q15(i_s_tdata[39:24]);
        w_req.color.blue   = tfc_pkg::clamp_q15(i_s_tdata[55:40]);
        w_req.color.alpha  = tfc_pkg::clamp_q15(i_s_tdata[71:56]);
    end

    assign o_s_tready   = (r_count != CntW'(QUEUE_DEPTH));
    assign w_push       = i_s_tvalid && o_s_tready;
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_queue[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### src/tfc_back.sv
// ----------------------------------------------------------------------------
// tfc_back
// Transfer table memory, front-to-back accumulator sequencer, cutoff
// register and the output register of the pixel channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tfc_back #(
    parameter int TABLE_ENTRIES = tfc_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tfc_pkg::t_req i_head,
    input  wire logic          i_head_valid,
    output logic               o_pop,
    input  wire logic          i_cfg_wr_en,
    input  wire logic [15:0]   i_cfg_wr_data,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic [31:0]        o_m_tdata,
    output logic               o_m_tuser
);

    localparam int AddrW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_BLEND,
        S_EMIT
    } t_state;

    t_state r_state;

    tfc_pkg::t_rgba r_table [TABLE_ENTRIES];
    tfc_pkg::t_rgba r_rd_data;

    logic [15:0] r_cutoff;
    logic [15:0] r_acc_red, r_acc_green, r_acc_blue, r_acc_alpha;
    logic        r_sat;
    logic        r_oor, r_last, r_stop;
    logic [15:0] r_t_red, r_t_green, r_t_blue, r_t_alpha;
    logic        r_m_valid;
    logic [31:0] r_m_data;
    logic        r_m_user;

    logic            w_tbl_we, w_tbl_re;
    logic [AddrW-1:0] w_addr;
    tfc_pkg::t_rgba  w_lut;
    logic [15:0]     w_weight;
    logic [15:0]     n_acc_red, n_acc_green, n_acc_blue, n_acc_alpha;
    logic            w_out_free, w_emit;

    assign o_pop    = (r_state == S_IDLE) && i_head_valid;
    assign w_tbl_we = o_pop && (i_head.kind == tfc_pkg::REQ_TABLE_WRITE) && !i_head.out_of_range;
    assign w_tbl_re = o_pop && (i_head.kind == tfc_pkg::REQ_COMPOSITE);
    assign w_addr   = AddrW'(i_head.index);

    always_ff @(posedge i_clk) begin
        if (w_tbl_we) begin
            r_table[w_addr] <= i_head.color;
        end
        if (w_tbl_re) begin
            r_rd_data <= r_table[w_addr];
        end
    end

    // an index outside the table reads as a clear entry
    assign w_lut    = r_oor ? '0 : r_rd_data;
    assign w_weight = tfc_pkg::ONE_Q15 - r_acc_alpha;

    assign n_acc_red   = tfc_pkg::add_sat_q15(r_acc_red, tfc_pkg::mul_q15(r_t_red, w_weight));
    assign n_acc_green = tfc_pkg::add_sat_q15(r_acc_green,
                                              tfc_pkg::mul_q15(r_t_green, w_weight));
    assign n_acc_blue  = tfc_pkg::add_sat_q15(r_acc_blue, tfc_pkg::mul_q15(r_t_blue, w_weight));
    assign n_acc_alpha = tfc_pkg::add_sat_q15(r_acc_alpha, r_t_alpha);

    assign w_out_free = !r_m_valid || i_m_tready;
    assign w_emit     = (r_state == S_EMIT) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cutoff    <= tfc_pkg::CUTOFF_RESET;
            r_acc_red   <= '0;
            r_acc_green <= '0;
            r_acc_blue  <= '0;
            r_acc_alpha <= '0;
            r_sat       <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cutoff <= i_cfg_wr_data;
            end
            if (w_emit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_tbl_re) begin
                        r_oor   <= i_head.out_of_range;
                        r_last  <= i_head.last;
                        r_stop  <= r_sat || (r_acc_alpha >= r_cutoff);
                        r_state <= S_LOOKUP;
                    end
                end
                S_LOOKUP: begin
                    r_t_red   <= tfc_pkg::mul_q15(w_lut.red, w_lut.alpha);
                    r_t_green <= tfc_pkg::mul_q15(w_lut.green, w_lut.alpha);
                    r_t_blue  <= tfc_pkg::mul_q15(w_lut.blue, w_lut.alpha);
                    r_t_alpha <= tfc_pkg::mul_q15(w_lut.alpha, w_weight);
                    r_state   <= S_BLEND;
                end
                S_BLEND: begin
                    if (r_stop) begin
                        r_sat <= 1'b1;
                    end else begin
                        r_acc_red   <= n_acc_red;
                        r_acc_green <= n_acc_green;
                        r_acc_blue  <= n_acc_blue;
                        r_acc_alpha <= n_acc_alpha;
                    end
                    r_state <= r_last ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_m_data    <= {tfc_pkg::to_byte(r_acc_alpha),
                                        tfc_pkg::to_byte(r_acc_blue),
                                        tfc_pkg::to_byte(r_acc_green),
                                        tfc_pkg::to_byte(r_acc_red)};
                        r_m_user    <= r_stop;
                        r_acc_red   <= '0;
                        r_acc_green <= '0;
                        r_acc_blue  <= '0;
                        r_acc_alpha <= '0;
                        r_sat       <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    // ray end leaves a cleared accumulator and a pending pixel
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_acc_alpha == '0 && r_acc_red == '0 && !r_sat && r_m_valid))
        else $error("accumulator not cleared after pixel emit");

    // a stopped ray does not move the accumulator
    a_stop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BLEND && r_stop)
        |=> $stable({r_acc_red, r_acc_green, r_acc_blue, r_acc_alpha}))
        else $error("accumulator changed after cutoff");

    // saturation keeps every channel at or below 1.0
    a_acc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BLEND) |=> (r_acc_alpha <= tfc_pkg::ONE_Q15
                                  && r_acc_red <= tfc_pkg::ONE_Q15
                                  && r_acc_green <= tfc_pkg::ONE_Q15
                                  && r_acc_blue <= tfc_pkg::ONE_Q15))
        else $error("accumulator above 1.0");

endmodule

`default_nettype wire

### src/tf_front_to_back_compositor_unit.sv
// ----------------------------------------------------------------------------
// tf_front_to_back_compositor_unit
// Front-to-back RGBA compositor of ray samples through a transfer table.
// ----------------------------------------------------------------------------
// Input stream: tuser selects a table write (0) or a sample (1); a write
// stores the clamped RGBA entry at tf_index, a sample looks up sample_value
// and blends it into the ray accumulator. tlast marks the last sample of a
// ray, which yields one pixel beat (RGBA bytes, tuser = early stop).
// Config: i_cfg_wr_en/i_cfg_wr_data load the Q1.15 opacity cutoff.
// Timing: each beat is registered in the queue (4 entries by default) before
// the back end can pop it. A table write is done as it is popped; a sample
// passes through three steps (table read, color times opacity, weight and
// accumulate), and this accumulator feedback keeps the back end from popping
// a new sample until the last one has finished. A ray end adds an emit step
// that loads the pixel register once the output register is free.
// Reset: accumulator and early-stop state clear, cutoff returns to 32440;
// table contents stay undefined until written.
// Stall: the pixel register holds while i_m_tready is low; the back end
// waits at ray end, the queue fills, then o_s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module tf_front_to_back_compositor_unit #(
    parameter int TABLE_ENTRIES = tfc_pkg::TABLE_ENTRIES_DEF,
    parameter int QUEUE_DEPTH   = tfc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    // tf_index[7:0], tf_red[23:8], tf_green[39:24], tf_blue[55:40],
    // tf_alpha[71:56], sample_value[79:72]
    input  wire logic [79:0]   i_s_tdata,
    input  wire logic          i_s_tuser,   // req_type
    input  wire logic          i_s_tlast,   // ray_last
    input  wire logic          i_cfg_wr_en,
    input  wire logic [15:0]   i_cfg_wr_data,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    // pixel_red[7:0], pixel_green[15:8], pixel_blue[23:16], pixel_alpha[31:24]
    output logic [31:0]        o_m_tdata,
    output logic               o_m_tuser    // early_stop
);

    tfc_pkg::t_req w_head;
    logic          w_head_valid;
    logic          w_pop;

    tfc_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .QUEUE_DEPTH   (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_s_tlast    (i_s_tlast),
        .o_head       (w_head),
        .o_head_valid (w_head_valid),
        .i_pop        (w_pop)
    );

    tfc_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_head_valid  (w_head_valid),
        .o_pop         (w_pop),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser)
    );

endmodule

`default_nettype wire

### verif/tf_front_to_back_compositor_unit_test.sv
// ----------------------------------------------------------------------------
// tf_front_to_back_compositor_unit_test
// Self-checking bench for the transfer-table compositor: a short table of
// hand-picked beats, then random rays under several opacity cutoffs. Each
// accepted input beat runs through a local Q1.15 model of the blend; every
// pixel beat is compared field by field against the oldest predicted pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module tf_front_to_back_compositor_unit_test;

    localparam int CLK_HALF     = 6;
    localparam int DRAIN_CYCLES = 30;
    localparam int LONG_HOLD    = 400;
    localparam int STALL_LIMIT  = 3000;

    typedef struct {
        tfc_pkg::t_req_kind kind;
        logic [7:0]  idx;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
        logic [7:0]  sample;
        logic        last;
    } t_beat;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       early;
    } t_pixel;

    typedef struct {
        t_beat  beat;
        bit     typed;
        t_pixel px;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [79:0] i_s_tdata = '0;
    logic        i_s_tuser = 1'b0;
    logic        i_s_tlast = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;
    logic        o_m_tuser;

    tf_front_to_back_compositor_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .i_s_tlast     (i_s_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ---- compositing model state ----
    tfc_pkg::t_rgba lut [256];
    int unsigned ray_r, ray_g, ray_b, ray_a;
    bit          ray_stopped;
    int unsigned cutoff_q15 = tfc_pkg::CUTOFF_RESET;

    t_pixel pixel_q [$];
    t_row   directed_rows [$];

    int  fails = 0;
    int  beats_in = 0, table_writes = 0, samples_in = 0;
    int  pixels_out = 0, early_stops = 0, cutoff_loads = 0, long_holds = 0;
    int  burst_left = 0;
    int  idle_cycles = 0;
    bit  steady_sender = 1'b0;
    bit  hold_go = 1'b0;

    function automatic int unsigned clip_one(input int unsigned v);
        return (v > tfc_pkg::ONE_Q15) ? tfc_pkg::ONE_Q15 : v;
    endfunction

    function automatic int unsigned q15_product(input int unsigned a, input int unsigned b);
        return (a * b) >> 15;
    endfunction

    function automatic logic [7:0] q15_to_byte(input int unsigned v);
        int unsigned p;
        p = (v * 255) >> 15;
        return p[7:0];
    endfunction

    function automatic logic [15:0] rand_q15();
        unique case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return tfc_pkg::ONE_Q15;
            2:       return 16'($urandom_range(32769, 65535));
            3, 4, 5: return 16'($urandom_range(0, 4095));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    // Advance the model by one accepted beat; a ray end yields a pixel.
    task automatic blend_beat(input t_beat b, output bit emits, output t_pixel px);
        tfc_pkg::t_rgba e;
        int unsigned w;
        bit          stopped_before;
        emits = 1'b0;
        px = '{default: '0};
        if (b.kind == tfc_pkg::REQ_TABLE_WRITE) begin
            lut[b.idx].red   = 16'(clip_one(b.red));
            lut[b.idx].green = 16'(clip_one(b.green));
            lut[b.idx].blue  = 16'(clip_one(b.blue));
            lut[b.idx].alpha = 16'(clip_one(b.alpha));
        end else begin
            stopped_before = ray_stopped || (ray_a >= cutoff_q15);
            if (stopped_before) begin
                ray_stopped = 1'b1;
            end else begin
                e = lut[b.sample];
                w = tfc_pkg::ONE_Q15 - ray_a;
                ray_r = clip_one(ray_r + q15_product(q15_product(e.red, e.alpha), w));
                ray_g = clip_one(ray_g + q15_product(q15_product(e.green, e.alpha), w));
                ray_b = clip_one(ray_b + q15_product(q15_product(e.blue, e.alpha), w));
                ray_a = clip_one(ray_a + q15_product(e.alpha, w));
            end
            if (b.last) begin
                emits = 1'b1;
                px.red   = q15_to_byte(ray_r);
                px.green = q15_to_byte(ray_g);
                px.blue  = q15_to_byte(ray_b);
                px.alpha = q15_to_byte(ray_a);
                px.early = stopped_before;
                ray_r = 0; ray_g = 0; ray_b = 0; ray_a = 0;
                ray_stopped = 1'b0;
            end
        end
    endtask

    // Offer one beat, hold it until accepted, then update the model.
    task automatic send_beat(input t_beat b, input bit typed, input t_pixel typed_px);
        bit     emits;
        t_pixel px;
        if (burst_left == 0) begin
            if (!steady_sender && $urandom_range(0, 3) != 0) begin
                i_s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= b.kind;
        i_s_tlast  <= b.last;
        i_s_tdata  <= {b.sample, b.alpha, b.blue, b.green, b.red, b.idx};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        beats_in++;
        if (b.kind == tfc_pkg::REQ_TABLE_WRITE) table_writes++;
        else samples_in++;
        blend_beat(b, emits, px);
        if (emits) pixel_q.insert(pixel_q.size(), typed ? typed_px : px);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_cutoff(input logic [15:0] v);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        cutoff_q15 = v;
        cutoff_loads++;
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic t_beat random_write(input logic [7:0] idx);
        t_beat b;
        b.kind   = tfc_pkg::REQ_TABLE_WRITE;
        b.idx    = idx;
        b.red    = rand_q15();
        b.green  = rand_q15();
        b.blue   = rand_q15();
        b.alpha  = rand_q15();
        b.sample = 8'($urandom);
        b.last   = 1'($urandom);
        return b;
    endfunction

    // Random rays of mostly short length, some long enough to hit the cutoff,
    // with table rewrites falling between and inside rays.
    task automatic run_rays(input int budget);
        t_beat  b;
        t_pixel none;
        int     sent;
        int     left;
        none = '{default: '0};
        sent = 0;
        left = 0;
        while (sent < budget || left != 0) begin
            if ($urandom_range(0, 9) == 0) begin
                b = random_write(8'($urandom));
            end else begin
                if (left == 0)
                    left = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 32)
                                                       : $urandom_range(1, 8);
                b.kind   = tfc_pkg::REQ_COMPOSITE;
                b.idx    = 8'($urandom);
                b.red    = 16'($urandom);
                b.green  = 16'($urandom);
                b.blue   = 16'($urandom);
                b.alpha  = 16'($urandom);
                b.sample = 8'($urandom_range(0, 255));
                b.last   = (left == 1);
                left--;
            end
            send_beat(b, 1'b0, none);
            sent++;
        end
    endtask

    task automatic add_row(input tfc_pkg::t_req_kind k, input logic [7:0] idx,
                           input logic [15:0] r, input logic [15:0] g,
                           input logic [15:0] bl, input logic [15:0] a,
                           input logic [7:0] s, input logic last, input bit typed,
                           input logic [7:0] pr, input logic [7:0] pg,
                           input logic [7:0] pb, input logic [7:0] pa, input logic pe);
        t_row row;
        row.beat  = '{kind: k, idx: idx, red: r, green: g, blue: bl, alpha: a,
                      sample: s, last: last};
        row.typed = typed;
        row.px    = '{red: pr, green: pg, blue: pb, alpha: pa, early: pe};
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // ---- stimulus ----
    initial begin : stimulus
        int     off;
        t_pixel none;
        none = '{default: '0};
        ray_r = 0; ray_g = 0; ray_b = 0; ray_a = 0;
        ray_stopped = 1'b0;

        // writes: opaque white, clear, over-range, half-alpha, opaque green
        add_row(tfc_pkg::REQ_TABLE_WRITE, 8'd0, 16'd32768, 16'd32768, 16'd32768, 16'd32768,
                8'hFF, 1'b1, 0, 0, 0, 0, 0, 0);
        add_row(tfc_pkg::REQ_TABLE_WRITE, 8'd1, 16'd0, 16'd0, 16'd0, 16'd0,
                8'hFF, 1'b0, 0, 0, 0, 0, 0, 0);
        add_row(tfc_pkg::REQ_TABLE_WRITE, 8'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                8'h00, 1'b1, 0, 0, 0, 0, 0, 0);
        add_row(tfc_pkg::REQ_TABLE_WRITE, 8'd255, 16'd32768, 16'd0, 16'd16384, 16'd16384,
                8'hAA, 1'b0, 0, 0, 0, 0, 0, 0);
        add_row(tfc_pkg::REQ_TABLE_WRITE, 8'd128, 16'd0, 16'd32768, 16'd0, 16'd32768,
                8'h55, 1'b1, 0, 0, 0, 0, 0, 0);
        // cutoff reached on the last sample itself: no early stop
        add_row(tfc_pkg::REQ_COMPOSITE, 8'h00, 16'h0, 16'h0, 16'h0, 16'h0,
                8'd0, 1'b1, 1, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        add_row(tfc_pkg::REQ_COMPOSITE, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                8'd1, 1'b1, 1, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        add_row(tfc_pkg::REQ_COMPOSITE, 8'h00, 16'h0, 16'h0, 16'h0, 16'h0,
                8'd2, 1'b1, 1, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        // opaque sample then one more: the last one is ignored
        add_row(tfc_pkg::REQ_COMPOSITE, 8'h00, 16'h0, 16'h0, 16'h0, 16'h0,
                8'd0, 1'b0, 0, 0, 0, 0, 0, 0);
        add_row(tfc_pkg::REQ_COMPOSITE, 8'h00, 16'h0, 16'h0, 16'h0, 16'h0,
                8'd1, 1'b1, 1, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        add_row(tfc_pkg::REQ_COMPOSITE, 8'h00, 16'h0, 16'h0, 16'h0, 16'h0,
                8'd128, 1'b1, 1, 8'd0, 8'd255, 8'd0, 8'd255, 1'b0);
        add_row(tfc_pkg::REQ_COMPOSITE, 8'h00, 16'h0, 16'h0, 16'h0, 16'h0,
                8'd255, 1'b0, 0, 0, 0, 0, 0, 0);
        add_row(tfc_pkg::REQ_COMPOSITE, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                8'd255, 1'b0, 0, 0, 0, 0, 0, 0);
        add_row(tfc_pkg::REQ_COMPOSITE, 8'h00, 16'h0, 16'h0, 16'h0, 16'h0,
                8'd255, 1'b1, 0, 0, 0, 0, 0, 0);
        add_row(tfc_pkg::REQ_COMPOSITE, 8'h5A, 16'hFFFF, 16'h1234, 16'h8000, 16'hFFFF,
                8'd1, 1'b0, 0, 0, 0, 0, 0, 0);
        add_row(tfc_pkg::REQ_COMPOSITE, 8'hA5, 16'h0, 16'h0, 16'h0, 16'h0,
                8'd255, 1'b1, 0, 0, 0, 0, 0, 0);
        add_row(tfc_pkg::REQ_TABLE_WRITE, 8'h55, 16'd12345, 16'd23456, 16'd32767, 16'd1,
                8'h00, 1'b0, 0, 0, 0, 0, 0, 0);
        add_row(tfc_pkg::REQ_TABLE_WRITE, 8'hAA, 16'd1, 16'd2, 16'd3, 16'd32767,
                8'hFF, 1'b1, 0, 0, 0, 0, 0, 0);
        add_row(tfc_pkg::REQ_COMPOSITE, 8'h00, 16'h0, 16'h0, 16'h0, 16'h0,
                8'h55, 1'b0, 0, 0, 0, 0, 0, 0);
        add_row(tfc_pkg::REQ_COMPOSITE, 8'h00, 16'h0, 16'h0, 16'h0, 16'h0,
                8'hAA, 1'b0, 0, 0, 0, 0, 0, 0);
        add_row(tfc_pkg::REQ_COMPOSITE, 8'h00, 16'h0, 16'h0, 16'h0, 16'h0,
                8'h55, 1'b1, 0, 0, 0, 0, 0, 0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].px);

        // fill every entry once so any sample value may be looked up
        off = $urandom_range(0, 255);
        for (int i = 0; i < 256; i++)
            send_beat(random_write(8'((i * 167 + off) & 255)), 1'b0, none);

        load_cutoff(16'd0);
        run_rays(60);

        // receiver holds off for a long stretch while beats keep coming
        load_cutoff(tfc_pkg::ONE_Q15);
        steady_sender = 1'b1;
        hold_go = 1'b1;
        run_rays(200);
        steady_sender = 1'b0;

        load_cutoff(16'hFFFF);
        run_rays(150);
        load_cutoff(16'd1);
        run_rays(100);
        load_cutoff(16'd16384);
        run_rays(150);
        load_cutoff(16'($urandom_range(0, 32768)));
        run_rays(200);
        load_cutoff(tfc_pkg::CUTOFF_RESET);
        run_rays(350);

        wait_drained();
        $display("%0d beats accepted: %0d table writes, %0d samples, %0d cutoff loads",
                 beats_in, table_writes, samples_in, cutoff_loads);
        $display("%0d pixels checked, %0d with early stop, %0d long output hold-offs",
                 pixels_out, early_stops, long_holds);
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // ---- receiver backpressure ----
    initial begin : receiver
        int mode;
        int n;
        @(posedge i_clk);
        forever begin
            if (hold_go) begin
                hold_go = 1'b0;
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_holds++;
            end else begin
                mode = $urandom_range(0, 3);
                n = (mode == 2) ? $urandom_range(1, 8) : $urandom_range(1, 30);
                repeat (n) begin
                    unique case (mode)
                        0:       i_m_tready <= 1'b1;
                        1:       i_m_tready <= 1'($urandom);
                        2:       i_m_tready <= 1'b0;
                        default: i_m_tready <= ($urandom_range(0, 3) != 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("pixel %0d %s: expected %0d, got %0d", pixels_out, name, want, got);
            fails++;
        end
    endfunction

    // ---- output check ----
    always @(posedge i_clk) begin : pixel_check
        t_pixel want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pixel_q.size() == 0) begin
                $error("pixel beat with nothing expected: tdata %h tuser %b",
                       o_m_tdata, o_m_tuser);
                fails++;
            end else begin
                want = pixel_q.pop_front();
                check_field("pixel_red",   want.red,   o_m_tdata[7:0]);
                check_field("pixel_green", want.green, o_m_tdata[15:8]);
                check_field("pixel_blue",  want.blue,  o_m_tdata[23:16]);
                check_field("pixel_alpha", want.alpha, o_m_tdata[31:24]);
                check_field("early_stop",  want.early, o_m_tuser);
                if (want.early) early_stops++;
                pixels_out++;
            end
        end
    end

    // ---- watchdog: no beat moving on either side for too long ----
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat accepted in %0d cycles, %0d pixels pending",
                     STALL_LIMIT, pixel_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

`default_nettype wire
